/* rtl/core/eur_pkg.sv */
// eur_pkg: shared widths, register indexes and item types of the echo ranger core
// no dependencies; imported by every other file of the core
`default_nettype none

package eur_pkg;

	localparam int NumSensors = 4;
	localparam int SensW      = 2;
	localparam int SelCmpW    = SensW + 1;
	localparam int EchoW      = 4;
	localparam int TickW      = 16;
	localparam int PerW       = 8;
	localparam int ScaleW     = 16;
	localparam int ProdW      = TickW + ScaleW;
	localparam int DistShift  = 8;
	localparam int DistW      = 24;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 16;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TRIG_LOW   = 3'd0,
		CFG_TRIG_HIGH  = 3'd1,
		CFG_SETTLE     = 3'd2,
		CFG_PERIOD     = 3'd3,
		CFG_SCALE      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [TickW-1:0]  trigger_low_ticks;
		logic [TickW-1:0]  trigger_high_ticks;
		logic [TickW-1:0]  settle_ticks;
		logic [PerW-1:0]   count_period_ticks;
		logic [ScaleW-1:0] distance_scale_q16;
	} cfg_t;

	typedef struct packed {
		logic             command;
		logic [SensW-1:0] sensor_select;
		logic [EchoW-1:0] echo_levels;
	} tick_item_t;

	typedef struct packed {
		logic [EchoW-1:0] trigger_lines;
		logic             busy_res;
		logic             done_res;
		logic [SensW-1:0] measured_sensor;
		logic [DistW-1:0] distance_q8;
	} report_item_t;

endpackage

`default_nettype wire

/* rtl/core/eur_if.sv */
// eur_tick_if and eur_report_if: valid/ready channels of the echo ranger core
// depends on eur_pkg
`default_nettype none

interface eur_tick_if import eur_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             command;
	logic [SensW-1:0] sensor_select;
	logic [EchoW-1:0] echo_levels;

	modport source (output valid, output command, output sensor_select,
		output echo_levels, input ready);
	modport sink (input valid, input command, input sensor_select,
		input echo_levels, output ready);
endinterface

interface eur_report_if import eur_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EchoW-1:0] trigger_lines;
	logic             busy_res;
	logic             done_res;
	logic [SensW-1:0] measured_sensor;
	logic [DistW-1:0] distance_q8;

	modport source (output valid, output trigger_lines, output busy_res,
		output done_res, output measured_sensor, output distance_q8, input ready);
	modport sink (input valid, input trigger_lines, input busy_res,
		input done_res, input measured_sensor, input distance_q8, output ready);
endinterface

`default_nettype wire

/* rtl/core/eur_cfg.sv */
// eur_cfg: configuration register file of the echo ranger core
// depends on eur_pkg
`default_nettype none

module eur_cfg import eur_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_low_ticks  <= TickW'(6);
			cfg_q.trigger_high_ticks <= TickW'(20);
			cfg_q.settle_ticks       <= TickW'(500);
			cfg_q.count_period_ticks <= PerW'(4);
			cfg_q.distance_scale_q16 <= ScaleW'(6884);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIG_LOW:  cfg_q.trigger_low_ticks  <= cfg_data[TickW-1:0];
				CFG_TRIG_HIGH: cfg_q.trigger_high_ticks <= cfg_data[TickW-1:0];
				CFG_SETTLE:    cfg_q.settle_ticks       <= cfg_data[TickW-1:0];
				CFG_PERIOD:    cfg_q.count_period_ticks <= cfg_data[PerW-1:0];
				CFG_SCALE:     cfg_q.distance_scale_q16 <= cfg_data[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/eur_dist.sv */
// eur_dist: period count times Q16 scale, scaled down to centimetres in Q8
// depends on eur_pkg
`default_nettype none

module eur_dist import eur_pkg::*; (
	input  wire logic [TickW-1:0]  period_count,
	input  wire logic [ScaleW-1:0] scale_q16,
	output      logic [DistW-1:0]  distance_q8
);

	logic [ProdW-1:0] prod;

	assign prod        = ProdW'(period_count) * ProdW'(scale_q16);
	assign distance_q8 = prod[DistShift +: DistW];

endmodule

`default_nettype wire

/* rtl/core/eur_seq.sv */
// eur_seq: trigger/settle/echo sequencer state and registered report payload
// depends on eur_pkg and eur_dist
`default_nettype none

module eur_seq import eur_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire tick_item_t item_s1,
	input  wire cfg_t       cfg,
	output report_item_t    report_q
);

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TRIG_LOW  = 3'd1,
		PH_TRIG_HIGH = 3'd2,
		PH_SETTLE    = 3'd3,
		PH_WAIT_RISE = 3'd4,
		PH_COUNT     = 3'd5
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [TickW-1:0]   tick_cnt_q, tick_cnt_d, tick_inc, limit;
	logic [PerW-1:0]    sub_q, sub_d, sub_next, per;
	logic [PerW:0]      sub_inc;
	logic [TickW-1:0]   echo_cnt_q, echo_cnt_d;
	logic [SensW-1:0]   active_q, active_d;
	logic               echo_high, done;
	logic [DistW-1:0]   prod_dist;

	// skip timed phases of zero length
	function automatic phase_t enter_phase(input phase_t p, input cfg_t c);
		phase_t r;
		r = p;
		if (r == PH_TRIG_LOW && c.trigger_low_ticks == '0)
			r = PH_TRIG_HIGH;
		if (r == PH_TRIG_HIGH && c.trigger_high_ticks == '0)
			r = PH_SETTLE;
		if (r == PH_SETTLE && c.settle_ticks == '0)
			r = PH_WAIT_RISE;
		return r;
	endfunction

	eur_dist u_dist (
		.period_count (echo_cnt_q),
		.scale_q16    (cfg.distance_scale_q16),
		.distance_q8  (prod_dist)
	);

	assign echo_high = item_s1.echo_levels[active_q];
	assign per       = (cfg.count_period_ticks == '0) ? PerW'(1) : cfg.count_period_ticks;
	assign sub_inc   = {1'b0, sub_q} + (PerW+1)'(1);
	assign sub_next  = (sub_inc >= {1'b0, per}) ? '0 : sub_inc[PerW-1:0];
	assign tick_inc  = tick_cnt_q + TickW'(1);

	always_comb begin
		phase_d    = phase_q;
		tick_cnt_d = tick_cnt_q;
		sub_d      = sub_q;
		echo_cnt_d = echo_cnt_q;
		active_d   = active_q;
		done       = 1'b0;
		limit      = cfg.settle_ticks;
		unique case (phase_q)
			PH_IDLE: begin
				if (item_s1.command &&
					({1'b0, item_s1.sensor_select} < SelCmpW'(NumSensors))) begin
					active_d   = item_s1.sensor_select;
					echo_cnt_d = '0;
					sub_d      = '0;
					phase_d    = enter_phase(PH_TRIG_LOW, cfg);
					tick_cnt_d = '0;
				end
			end
			PH_TRIG_LOW, PH_TRIG_HIGH, PH_SETTLE: begin
				if (phase_q == PH_TRIG_LOW)
					limit = cfg.trigger_low_ticks;
				else if (phase_q == PH_TRIG_HIGH)
					limit = cfg.trigger_high_ticks;
				tick_cnt_d = tick_inc;
				if (tick_inc >= limit) begin
					tick_cnt_d = '0;
					if (phase_q == PH_TRIG_LOW)
						phase_d = enter_phase(PH_TRIG_HIGH, cfg);
					else if (phase_q == PH_TRIG_HIGH)
						phase_d = enter_phase(PH_SETTLE, cfg);
					else
						phase_d = PH_WAIT_RISE;
				end
			end
			PH_WAIT_RISE: begin
				if (echo_high) begin
					echo_cnt_d = TickW'(1);
					sub_d      = (per == PerW'(1)) ? '0 : PerW'(1);
					phase_d    = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (sub_q != '0) begin
					sub_d = sub_next;
				end else if (echo_high) begin
					if (echo_cnt_q != '1)
						echo_cnt_d = echo_cnt_q + TickW'(1);
					sub_d = sub_next;
				end else begin
					done    = 1'b1;
					phase_d = PH_IDLE;
					sub_d   = '0;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_cnt_q <= '0;
			sub_q      <= '0;
			echo_cnt_q <= '0;
			active_q   <= '0;
			report_q   <= '0;
		end else if (adv) begin
			phase_q    <= phase_d;
			tick_cnt_q <= tick_cnt_d;
			sub_q      <= sub_d;
			echo_cnt_q <= echo_cnt_d;
			active_q   <= active_d;
			report_q.trigger_lines   <= (phase_d == PH_TRIG_HIGH) ?
				(EchoW'(1) << active_d) : '0;
			report_q.busy_res        <= (phase_d != PH_IDLE);
			report_q.done_res        <= done;
			report_q.measured_sensor <= active_d;
			report_q.distance_q8     <= done ? prod_dist : '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ultrasonic_echo_ranger_core.sv */
// ultrasonic_echo_ranger_core: top level of the four-channel echo ranger
// depends on eur_pkg, eur_if, eur_cfg, eur_seq
//
//   channel  | dir | contents
//   tick     | in  | command, sensor_select, echo_levels; one time tick
//   report   | out | trigger_lines, busy_res, done_res, measured_sensor, distance_q8
//   cfg_*    | in  | write enable, register index, 16-bit data
//
// one item a cycle sustained while the report is not stalled; a tick passes the tick register, then the report register
// the tick register feeds the sequencer and the product of period count and scale
// registered into the report register in the same cycle
// a stalled report holds both stages; the tick register still takes an item if empty
// reset clears valid flags, sequencer state and configuration to defaults
`default_nettype none

module ultrasonic_echo_ranger_core import eur_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	eur_tick_if.sink                 tick,
	eur_report_if.source             report,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	cfg_t         cfg;
	tick_item_t   item_s1;
	logic         valid_s1;
	logic         res_valid_q;
	logic         adv;
	report_item_t report_q;

	assign adv        = valid_s1 && (!res_valid_q || report.ready);
	assign tick.ready = !valid_s1 || !res_valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (tick.ready)
				valid_s1 <= tick.valid;
			if (adv)
				res_valid_q <= 1'b1;
			else if (report.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			item_s1.command       <= tick.command;
			item_s1.sensor_select <= tick.sensor_select;
			item_s1.echo_levels   <= tick.echo_levels;
		end
	end

	eur_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eur_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item_s1  (item_s1),
		.cfg      (cfg),
		.report_q (report_q)
	);

	assign report.valid           = res_valid_q;
	assign report.trigger_lines   = report_q.trigger_lines;
	assign report.busy_res        = report_q.busy_res;
	assign report.done_res        = report_q.done_res;
	assign report.measured_sensor = report_q.measured_sensor;
	assign report.distance_q8     = report_q.distance_q8;

endmodule

`default_nettype wire

/* rtl/core/eur_checker.sv */
// eur_checker: port-level assertions for the echo ranger core, bound to the top level
// depends on eur_pkg and ultrasonic_echo_ranger_core
`default_nettype none

module eur_checker import eur_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rep_valid,
	input wire logic             rep_ready,
	input wire logic [EchoW-1:0] trigger_lines,
	input wire logic             busy_res,
	input wire logic             done_res,
	input wire logic [SensW-1:0] measured_sensor,
	input wire logic [DistW-1:0] distance_q8
);

	// distance only shows on the done item
	a_dist_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !done_res |-> distance_q8 == '0)
		else $error("distance nonzero outside done item");

	// a finished measurement leaves the block idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && done_res |-> !busy_res)
		else $error("done item reports busy");

	// at most one trigger, only while busy, on the measured sensor
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && trigger_lines != '0 |->
			busy_res && $onehot(trigger_lines) && trigger_lines[measured_sensor])
		else $error("trigger line inconsistent with measurement");

	// stalled report item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !rep_ready |=> rep_valid && $stable(trigger_lines) &&
			$stable(busy_res) && $stable(done_res) && $stable(measured_sensor) &&
			$stable(distance_q8))
		else $error("report item changed under stall");

endmodule

bind ultrasonic_echo_ranger_core eur_checker u_eur_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rep_valid       (report.valid),
	.rep_ready       (report.ready),
	.trigger_lines   (report.trigger_lines),
	.busy_res        (report.busy_res),
	.done_res        (report.done_res),
	.measured_sensor (report.measured_sensor),
	.distance_q8     (report.distance_q8)
);

`default_nettype wire
